/* rtl/smm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types and constants of the small matrix multiply unit.
// ----------------------------------------------------------------------------
package smm_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int FRAC_BITS   = 8;
  localparam int VAL_W       = 16;
  localparam int POS_W       = 6;
  localparam int DIM_W       = 4;
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  typedef struct packed {
    logic             operand_sel;
    logic [POS_W-1:0] position;
    logic signed [VAL_W-1:0] elem_value;
    logic             go;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] out_position;
    logic signed [VAL_W-1:0] out_value;
    logic             last;
  } out_item_t;

  // Control carried down the cell chain next to each operand pair.
  typedef struct packed {
    logic             valid;
    logic             first_k;
    logic             last_k;
    logic             last_elem;
    logic [POS_W-1:0] pos;
  } mac_ctl_t;

endpackage

/* rtl/smm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/smm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_cell
// One cell of the chain: registers its inputs and hands them on.
// The multiply cell forms the product, the accumulate cell sums it.
// ----------------------------------------------------------------------------
module smm_cell #(
  parameter int ROLE = 0  // 0 multiply, 1 accumulate
) (
  input  logic                  clk,
  input  logic                  rst,
  input  smm_pkg::mac_ctl_t     ctl_in,
  input  logic signed [39:0]    a_in,
  input  logic signed [39:0]    b_in,
  output smm_pkg::mac_ctl_t     ctl_out,
  output logic signed [39:0]    data_out
);
  logic signed [39:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  generate
    if (ROLE == 0) begin : g_mul
      always_ff @(posedge clk) begin
        acc <= 40'($signed(a_in[15:0]) * $signed(b_in[15:0]));
      end
    end else begin : g_acc
      always_ff @(posedge clk) begin
        if (ctl_in.valid) begin
          acc <= ctl_in.first_k ? a_in : acc + a_in;
        end
      end
    end
  endgenerate

  // Multiply cell: a_in/b_in are signed 16-bit values sign-extended.
  assign data_out = (ROLE == 0) ? acc : acc + (b_in & 40'sd0);
endmodule

/* rtl/small_matrix_multiply_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_multiply_unit
// Element items are accepted while busy is low. A go item starts the product:
// one multiply-add per cycle, through a chain of read, multiply, accumulate
// and round cells.
// Results appear one per strobe and cannot be stalled; busy stays high
// until the last one is out. Reset sets dim to 8; stores are undefined.
// ----------------------------------------------------------------------------
module small_matrix_multiply_unit #(
  parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  smm_pkg::in_item_t    in_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [smm_pkg::DIM_W-1:0] cfg_data,
  output logic                 out_strobe,
  output smm_pkg::out_item_t   out_item
);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_DIM + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;

  logic [1:0] state;
  logic [smm_pkg::DIM_W-1:0] dim;
  logic [CW-1:0] n, i, j, k;
  logic [2:0] tail;
  logic accept;

  assign accept    = start && !busy;
  assign cfg_ready = (state == S_IDLE);
  assign busy      = (state != S_IDLE);

  always_comb begin
    if (dim == '0) begin
      n = CW'(1);
    end else if ({{(32-smm_pkg::DIM_W){1'b0}}, dim} > MAX_DIM) begin
      n = CW'(MAX_DIM);
    end else begin
      n = CW'(dim);
    end
  end

  logic wr_ok;
  assign wr_ok = accept && ({{(32-smm_pkg::POS_W){1'b0}}, in_item.position} < DEPTH);

  // Address of first(i,k) and second(k,j).
  logic [AW-1:0] addr_a, addr_b;
  assign addr_a = AW'(32'(i) + 32'(k) * 32'(n));
  assign addr_b = AW'(32'(k) + 32'(j) * 32'(n));

  logic [smm_pkg::VAL_W-1:0] ra, rb;

  smm_ram #(.WIDTH(smm_pkg::VAL_W), .DEPTH(DEPTH)) u_first (
    .clk(clk), .we(wr_ok && !in_item.operand_sel),
    .waddr(AW'(in_item.position)), .wdata(in_item.elem_value),
    .raddr(addr_a), .rdata(ra)
  );
  smm_ram #(.WIDTH(smm_pkg::VAL_W), .DEPTH(DEPTH)) u_second (
    .clk(clk), .we(wr_ok && in_item.operand_sel),
    .waddr(AW'(in_item.position)), .wdata(in_item.elem_value),
    .raddr(addr_b), .rdata(rb)
  );

  smm_pkg::mac_ctl_t ctl_issue, ctl_rd, ctl_mul, ctl_acc;
  logic running;
  assign running = (state == S_RUN);

  always_comb begin
    ctl_issue.valid     = running;
    ctl_issue.first_k   = (k == '0);
    ctl_issue.last_k    = (k == n - 1'b1);
    ctl_issue.last_elem = (i == n - 1'b1) && (j == n - 1'b1);
    ctl_issue.pos       = smm_pkg::POS_W'(32'(i) + 32'(j) * 32'(n));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dim   <= smm_pkg::DIM_RESET;
      ctl_rd <= '0;
      i <= '0; j <= '0; k <= '0; tail <= '0;
    end else begin
      ctl_rd <= ctl_issue;
      if (cfg_valid && cfg_ready) begin
        dim <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept && in_item.go) begin
            state <= S_RUN;
            i <= '0; j <= '0; k <= '0;
          end
        end
        S_RUN: begin
          if (k != n - 1'b1) begin
            k <= k + 1'b1;
          end else begin
            k <= '0;
            if (i != n - 1'b1) begin
              i <= i + 1'b1;
            end else begin
              i <= '0;
              if (j != n - 1'b1) begin
                j <= j + 1'b1;
              end else begin
                state <= S_TAIL;
                tail  <= 3'd5;
              end
            end
          end
        end
        S_TAIL: begin
          tail <= tail - 1'b1;
          if (tail == 3'd1) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic signed [39:0] prod, accv;

  smm_cell #(.ROLE(0)) u_mul (
    .clk(clk), .rst(rst), .ctl_in(ctl_rd),
    .a_in(40'(signed'(ra))), .b_in(40'(signed'(rb))),
    .ctl_out(ctl_mul), .data_out(prod)
  );
  smm_cell #(.ROLE(1)) u_acc (
    .clk(clk), .rst(rst), .ctl_in(ctl_mul),
    .a_in(prod), .b_in('0),
    .ctl_out(ctl_acc), .data_out(accv)
  );

  // Round half up, then saturate to Q8.8.
  logic signed [39:0] rnd;
  assign rnd = (accv + 40'sd128) >>> smm_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= ctl_acc.valid && ctl_acc.last_k;
    end
    out_item.out_position <= ctl_acc.pos;
    out_item.last         <= ctl_acc.last_elem;
    if (rnd > 40'sd32767) begin
      out_item.out_value <= 16'sh7FFF;
    end else if (rnd < -40'sd32768) begin
      out_item.out_value <= 16'sh8000;
    end else begin
      out_item.out_value <= rnd[15:0];
    end
  end
endmodule

/* tb/small_matrix_multiply_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_matrix_multiply_unit_test
// Loads pairs of square Q8.8 matrices at several dimensions, starts products
// with go items and checks every result element, in order, against a
// predictor that keeps its own copy of both stores and of the dimension.
// ----------------------------------------------------------------------------
module small_matrix_multiply_unit_test;

  localparam int STORE_DEPTH = smm_pkg::MAX_DIM_DEF * smm_pkg::MAX_DIM_DEF;

  class product_scoreboard;
    logic signed [smm_pkg::VAL_W-1:0] first_store[STORE_DEPTH];
    logic signed [smm_pkg::VAL_W-1:0] second_store[STORE_DEPTH];
    int unsigned active_dim;
    smm_pkg::out_item_t expected_q[$];
    int errors;

    function new();
      active_dim = smm_pkg::MAX_DIM_DEF;
      errors = 0;
      foreach (first_store[i]) begin
        first_store[i] = '0;
        second_store[i] = '0;
      end
    endfunction

    // A dimension of zero behaves as one, anything above the maximum as the maximum.
    function void set_dim(logic [smm_pkg::DIM_W-1:0] d);
      active_dim = (d == 0) ? 1 : (d > smm_pkg::MAX_DIM_DEF) ? smm_pkg::MAX_DIM_DEF : d;
    endfunction

    function logic signed [smm_pkg::VAL_W-1:0] round_q88(longint acc);
      longint r;
      r = (acc + (1 << (smm_pkg::FRAC_BITS - 1))) >>> smm_pkg::FRAC_BITS;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[smm_pkg::VAL_W-1:0];
    endfunction

    function void note_item(smm_pkg::in_item_t it);
      longint acc;
      smm_pkg::out_item_t res;
      int unsigned n;
      if (it.position < STORE_DEPTH) begin
        if (it.operand_sel) second_store[it.position] = it.elem_value;
        else first_store[it.position] = it.elem_value;
      end
      if (!it.go) return;
      n = active_dim;
      for (int j = 0; j < n; j++) begin
        for (int i = 0; i < n; i++) begin
          acc = 0;
          for (int k = 0; k < n; k++)
            acc += longint'(first_store[i + k * n]) * longint'(second_store[k + j * n]);
          res.out_position = smm_pkg::POS_W'(i + j * n);
          res.out_value = round_q88(acc);
          res.last = (i == n - 1) && (j == n - 1);
          expected_q.push_back(res);
        end
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(smm_pkg::out_item_t got);
      smm_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result pos=%0d val=%0d",
                                  got.out_position, got.out_value));
        return;
      end
      want = expected_q.pop_front();
      if (got.out_position !== want.out_position)
        report_mismatch($sformatf("position %0d, want %0d", got.out_position,
                                  want.out_position));
      if (got.out_value !== want.out_value)
        report_mismatch($sformatf("value %0d at pos %0d, want %0d", got.out_value,
                                  want.out_position, want.out_value));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b at pos %0d, want %0b", got.last,
                                  want.out_position, want.last));
    endtask
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  smm_pkg::in_item_t in_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [smm_pkg::DIM_W-1:0] cfg_data;
  logic out_strobe;
  smm_pkg::out_item_t out_item;

  product_scoreboard sb;
  bit calm;
  int items_sent = 0;

  small_matrix_multiply_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_strobe(out_strobe), .out_item(out_item)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && out_strobe) sb.check_result(out_item);
  end

  task send_item(smm_pkg::in_item_t it);
    // A stretch in the middle of the run drives items with no random gaps.
    calm = (items_sent > 50 && items_sent < 100);
    if (!calm && $urandom_range(0, 99) < 37) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_dim(logic [smm_pkg::DIM_W-1:0] d);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_dim(d);
  endtask

  function logic signed [smm_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return smm_pkg::VAL_W'($urandom);
      default: return smm_pkg::VAL_W'($signed($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  // Writes every element of both n-by-n operands in shuffled order, with go on
  // the final one, so the product never reads an unwritten entry.
  task load_product(int unsigned n, logic signed [smm_pkg::VAL_W-1:0] a_val,
                    logic signed [smm_pkg::VAL_W-1:0] b_val, bit random_vals,
                    output int sent);
    int unsigned order[$];
    smm_pkg::in_item_t it;
    sent = 0;
    for (int unsigned e = 0; e < 2 * n * n; e++) order.push_back(e);
    order.shuffle();
    foreach (order[x]) begin
      it.operand_sel = order[x] >= n * n;
      it.position = smm_pkg::POS_W'(order[x] % (n * n));
      if (random_vals) it.elem_value = pick_value();
      else it.elem_value = it.operand_sel ? b_val : a_val;
      it.go = (x == order.size() - 1);
      send_item(it);
      sent++;
    end
  endtask

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    smm_pkg::in_item_t it;
    int sent;
    int unsigned n;
    logic [smm_pkg::DIM_W-1:0] dims[8] = '{4'd15, 4'd0, 4'd3, 4'd9, 4'd2, 4'd5, 4'd1, 4'd8};

    sb = new();
    calm = 0;
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Rounding ties at dimension one: +0.5 LSB rounds up, -0.5 LSB to zero.
    write_dim(4'd1);
    send_item('{operand_sel: 1'b0, position: 6'd0, elem_value: 16'sd1, go: 1'b0});
    send_item('{operand_sel: 1'b1, position: 6'd0, elem_value: 16'sd128, go: 1'b1});
    send_item('{operand_sel: 1'b1, position: 6'd0, elem_value: -16'sd128, go: 1'b1});
    send_item('{operand_sel: 1'b1, position: 6'd0, elem_value: -16'sd129, go: 1'b1});
    // Saturation both ways at a small size.
    write_dim(4'd2);
    load_product(2, 16'sh7fff, 16'sh7fff, 0, sent);
    send_item('{operand_sel: 1'b1, position: 6'd3, elem_value: 16'sh8000, go: 1'b1});
    load_product(2, 16'sh8000, 16'sh7fff, 0, sent);

    for (int p = 0; items_sent < 160; p++) begin
      write_dim(dims[p % 8]);
      n = sb.active_dim;
      if (n > 4 && $urandom_range(0, 3) == 0) begin
        write_dim(4'($urandom_range(1, 4)));
        n = sb.active_dim;
      end
      // Keep the total number of items near its budget.
      while (n > 1 && items_sent + 2 * n * n + 7 > 180) n--;
      if (n != sb.active_dim) write_dim(smm_pkg::DIM_W'(n));
      load_product(n, 0, 0, 1, sent);
      // Overwrites inside and outside the active square, then another go.
      repeat ($urandom_range(1, 6)) begin
        it.operand_sel = $urandom_range(0, 1);
        it.position = smm_pkg::POS_W'($urandom_range(0, STORE_DEPTH - 1));
        it.elem_value = pick_value();
        it.go = 1'b0;
        send_item(it);
      end
      it.operand_sel = $urandom_range(0, 1);
      it.position = smm_pkg::POS_W'($urandom_range(0, n * n - 1));
      it.elem_value = pick_value();
      it.go = 1'b1;
      send_item(it);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
